// File: src/dcsl_pkg.sv
// Package for the DER certificate subject locator.
// Holds the status, header phase and walk step codes, the tag constants
// and the result type. No dependencies.
package dcsl_pkg;

	localparam int MAX_CERT_BYTES_DEF    = 65536;
	localparam int MAX_LENGTH_OCTETS_DEF = 8;

	// Tag numbers are compared on the low five bits of the tag byte.
	localparam logic [4:0] TAG_LONG     = 5'd31;
	localparam logic [4:0] TAG_INTEGER  = 5'd2;
	localparam logic [4:0] TAG_SEQUENCE = 5'd16;

	localparam logic [7:0] SHORT_MAX      = 8'd127;
	localparam logic [7:0] LEN_INDEFINITE = 8'h80;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_LONG_TAG   = 3'd1,
		ST_BAD_TYPE   = 3'd2,
		ST_BAD_LENGTH = 3'd3,
		ST_TRUNCATED  = 3'd4,
		ST_TOO_LONG   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_TAG  = 2'd0,
		PH_LEN  = 2'd1,
		PH_LONG = 2'd2,
		PH_SKIP = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		STEP_OUTER     = 3'd0,
		STEP_TBS       = 3'd1,
		STEP_INTEGER   = 3'd2,
		STEP_SIGNATURE = 3'd3,
		STEP_ISSUER    = 3'd4,
		STEP_VALIDITY  = 3'd5,
		STEP_SUBJECT   = 3'd6,
		STEP_DONE      = 3'd7
	} step_t;

	typedef struct packed {
		status_t      status;
		logic [15:0]  subject_offset;
		logic [16:0]  subject_length;
	} dcsl_result_t;

endpackage

// File: src/dcsl_in_if.sv
// Input channel of the subject locator: one certificate byte per item.
// Valid/ready handshake; no dependencies.
interface dcsl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

// File: src/dcsl_out_if.sv
// Result channel of the subject locator: one item per certificate.
// Valid/ready handshake; no dependencies.
interface dcsl_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] subject_offset;
	logic [16:0] subject_length;

	modport source (output valid, output status, output subject_offset,
		output subject_length, input ready);
	modport sink (input valid, input status, input subject_offset,
		input subject_length, output ready);
endinterface

// File: src/dcsl_walk.sv
// Header walker of the subject locator: keeps the TLV walk state and
// updates it for one byte per enabled cycle. Depends on dcsl_pkg.
module dcsl_walk
	import dcsl_pkg::*;
#(
	parameter int MAX_CERT_BYTES    = MAX_CERT_BYTES_DEF,
	parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [7:0]   data_byte,
	input  logic         last,
	output dcsl_result_t res
);

	localparam int PW = $clog2(MAX_CERT_BYTES + 2);
	localparam int EW = PW + 1;
	localparam int AW = PW + 8;
	localparam int OW = $clog2(MAX_LENGTH_OCTETS + 1);

	logic [PW-1:0] pos_q, pos_n;
	step_t         step_q, step_n;
	phase_t        phase_q, phase_n;
	logic [OW-1:0] left_q, left_n, left_dec;
	logic [PW-1:0] acc_q, acc_n;
	logic [PW-1:0] skip_q, skip_n, skip_dec;
	logic [PW-1:0] req_q, req_n;
	logic [PW-1:0] hs_q, hs_n;
	logic [15:0]   foff_q, foff_n;
	logic [16:0]   flen_q, flen_n;
	status_t       status_q, status_n;
	logic          done_q, done_n;

	logic [AW-1:0] acc_shift;
	logic [PW-1:0] acc_sat;
	logic [PW-1:0] len_c;
	logic [EW-1:0] end_c;
	logic          end_ok;
	logic [4:0]    tag_code;
	logic [4:0]    tag_want;
	logic          complete;
	status_t       status_fin;

	assign acc_shift = {acc_q, data_byte};
	assign acc_sat   = (acc_shift > AW'(MAX_CERT_BYTES)) ? PW'(MAX_CERT_BYTES + 1)
		: acc_shift[PW-1:0];
	assign len_c     = (phase_q == PH_LEN) ? PW'(data_byte) : acc_sat;
	assign end_c     = EW'(pos_q) + EW'(len_c) + EW'(1);
	assign end_ok    = end_c <= EW'(MAX_CERT_BYTES);
	assign left_dec  = (left_q != '0) ? left_q - OW'(1) : '0;
	assign skip_dec  = (skip_q != '0) ? skip_q - PW'(1) : '0;
	assign tag_code  = data_byte[4:0];
	assign tag_want  = (step_q == STEP_INTEGER) ? TAG_INTEGER : TAG_SEQUENCE;

	always_comb begin
		pos_n    = pos_q;
		step_n   = step_q;
		phase_n  = phase_q;
		left_n   = left_q;
		acc_n    = acc_q;
		skip_n   = skip_q;
		req_n    = req_q;
		hs_n     = hs_q;
		foff_n   = foff_q;
		flen_n   = flen_q;
		status_n = status_q;
		done_n   = done_q;
		complete = 1'b0;
		if (en && status_q == ST_OK) begin
			if (pos_q >= PW'(MAX_CERT_BYTES)) begin
				status_n = ST_TOO_LONG;
			end else begin
				pos_n = pos_q + PW'(1);
				if (!done_q) begin
					unique case (phase_q)
						PH_TAG: begin
							hs_n = pos_q;
							if (tag_code == TAG_LONG) begin
								status_n = ST_LONG_TAG;
							end else if (tag_code != tag_want) begin
								status_n = ST_BAD_TYPE;
							end else begin
								phase_n = PH_LEN;
							end
						end
						PH_LEN: begin
							if (data_byte <= SHORT_MAX) begin
								acc_n    = PW'(data_byte);
								complete = 1'b1;
							end else if (data_byte == LEN_INDEFINITE) begin
								status_n = ST_BAD_LENGTH;
							end else if (data_byte[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
								status_n = ST_BAD_LENGTH;
							end else begin
								left_n  = OW'(data_byte[6:0]);
								acc_n   = '0;
								phase_n = PH_LONG;
							end
						end
						PH_LONG: begin
							acc_n  = acc_sat;
							left_n = left_dec;
							if (left_dec == '0) begin
								complete = 1'b1;
							end
						end
						PH_SKIP: begin
							skip_n = skip_dec;
							if (skip_dec == '0) begin
								phase_n = PH_TAG;
							end
						end
						default: begin
							phase_n = PH_TAG;
						end
					endcase
					if (complete) begin
						if (!end_ok) begin
							status_n = ST_TOO_LONG;
						end else begin
							if (end_c[PW-1:0] > req_q) begin
								req_n = end_c[PW-1:0];
							end
							if (step_q == STEP_OUTER || step_q == STEP_TBS) begin
								step_n  = step_t'(step_q + 3'd1);
								phase_n = PH_TAG;
							end else if (step_q != STEP_SUBJECT && step_q != STEP_DONE) begin
								// Skipped elements: step over their contents.
								step_n = step_t'(step_q + 3'd1);
								if (len_c == '0) begin
									phase_n = PH_TAG;
								end else begin
									skip_n  = len_c;
									phase_n = PH_SKIP;
								end
							end else begin
								foff_n = 16'(hs_q);
								flen_n = 17'(end_c - EW'(hs_q));
								done_n = 1'b1;
								step_n = STEP_DONE;
							end
						end
					end
				end
			end
		end
	end

	// The stream is short if the subject header never completed or an
	// element seen so far ends beyond the last byte.
	always_comb begin
		status_fin = status_n;
		if (status_n == ST_OK && (!done_n || req_n > pos_n)) begin
			status_fin = ST_TRUNCATED;
		end
		res.status         = status_fin;
		res.subject_offset = (status_fin == ST_OK) ? foff_n : '0;
		res.subject_length = (status_fin == ST_OK) ? flen_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			step_q   <= STEP_OUTER;
			phase_q  <= PH_TAG;
			left_q   <= '0;
			acc_q    <= '0;
			skip_q   <= '0;
			req_q    <= '0;
			hs_q     <= '0;
			foff_q   <= '0;
			flen_q   <= '0;
			status_q <= ST_OK;
			done_q   <= 1'b0;
		end else if (en && last) begin
			// The final byte closes the certificate; start over for the next one.
			pos_q    <= '0;
			step_q   <= STEP_OUTER;
			phase_q  <= PH_TAG;
			left_q   <= '0;
			acc_q    <= '0;
			skip_q   <= '0;
			req_q    <= '0;
			hs_q     <= '0;
			foff_q   <= '0;
			flen_q   <= '0;
			status_q <= ST_OK;
			done_q   <= 1'b0;
		end else begin
			pos_q    <= pos_n;
			step_q   <= step_n;
			phase_q  <= phase_n;
			left_q   <= left_n;
			acc_q    <= acc_n;
			skip_q   <= skip_n;
			req_q    <= req_n;
			hs_q     <= hs_n;
			foff_q   <= foff_n;
			flen_q   <= flen_n;
			status_q <= status_n;
			done_q   <= done_n;
		end
	end

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_CERT_BYTES))
		else $error("byte position beyond capacity");

	a_done_step: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> step_q == STEP_DONE)
		else $error("walk done without final step");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != ST_OK && !(en && last) |=> status_q == $past(status_q))
		else $error("latched fault changed before end of certificate");

endmodule

// File: src/der_certificate_subject_locator.sv
// Top level of the DER certificate subject locator: input register, header
// walker and result register. Depends on dcsl_pkg, dcsl_in_if, dcsl_out_if, dcsl_walk.
//
// The block takes one certificate byte per clock, back to back while its input does
// not stall, and returns one result item for each byte marked last: the status and,
// when the status is ok, the offset and total length of the subject element. A byte
// passes through the input register and the header walker's state update, which is
// the whole work for a byte; the result of a last byte is then held in the result
// register. The input side stalls only while a finished result waits to be taken
// and a further last byte sits in the input register.
module der_certificate_subject_locator
	import dcsl_pkg::*;
#(
	parameter int MAX_CERT_BYTES    = MAX_CERT_BYTES_DEF,
	parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dcsl_in_if.sink     cert,
	dcsl_out_if.source  result
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         advance;
	logic         res_valid_q;
	dcsl_result_t res_q;
	dcsl_result_t walk_res;

	// A byte leaves the input register unless it would produce a result while
	// the previous result is still waiting.
	assign advance    = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign cert.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cert.valid && cert.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cert.valid && cert.ready) begin
			byte_s1 <= cert.data_byte;
			last_s1 <= cert.last;
		end
	end

	dcsl_walk #(
		.MAX_CERT_BYTES    (MAX_CERT_BYTES),
		.MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.data_byte (byte_s1),
		.last      (last_s1),
		.res       (walk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= walk_res;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.status         = res_q.status;
	assign result.subject_offset = res_q.subject_offset;
	assign result.subject_length = res_q.subject_length;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cert.ready |-> valid_s1 && last_s1 && res_valid_q)
		else $error("input stalled without a pending result");

	a_fault_no_location: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != ST_OK
		|-> result.subject_offset == 16'd0 && result.subject_length == 17'd0)
		else $error("location reported with a fault status");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(valid_s1 && last_s1))
		else $error("result without a last byte");

endmodule

// File: tb/sv/tb.sv
// Testbench for der_certificate_subject_locator: feeds DER certificate bytes, predicts
// each status/offset/length item from its own header walk and checks every result.
// Depends on dcsl_pkg, dcsl_in_if, dcsl_out_if and the block's RTL.
module tb;
	import dcsl_pkg::*;

	localparam int CERT_CAP  = MAX_CERT_BYTES_DEF;
	localparam int HOLD_CYCS = 300;

	typedef logic [7:0] octets_t[$];
	typedef struct {
		logic [7:0] data;
		logic       last;
	} cert_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic [7:0] in_data = 8'h00;
	logic       in_last = 1'b0;
	logic       out_ready = 1'b0;

	dcsl_in_if  cert_if ();
	dcsl_out_if res_if ();

	assign cert_if.valid     = in_valid;
	assign cert_if.data_byte = in_data;
	assign cert_if.last      = in_last;
	assign res_if.ready      = out_ready;

	der_certificate_subject_locator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cert   (cert_if),
		.result (res_if)
	);

	always #10 clk = ~clk;

	cert_byte_t   feed_q[$];
	dcsl_result_t subject_q[$];
	dcsl_result_t head_r;
	cert_byte_t   next_r;
	int           queued_cnt = 0;
	int           taken_cnt = 0;
	int           fail_cnt = 0;
	int           phase_items = 0;
	int           phase_certs = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_left = 0;
	logic         hold_taken = 1'b0;
	logic         hold_req = 1'b0;

	// Predicted walk state.
	logic [16:0] pos_r;
	step_t       step_r;
	phase_t      ph_r;
	logic [3:0]  octs_r;
	logic [16:0] acc_r;
	logic [16:0] skip_r;
	logic [16:0] req_end_r;
	logic [16:0] hdr_start_r;
	logic [15:0] found_off_r;
	logic [16:0] found_len_r;
	status_t     fault_r;
	logic        done_r;

	function automatic void clear_walk();
		pos_r = '0;
		step_r = STEP_OUTER;
		ph_r = PH_TAG;
		octs_r = '0;
		acc_r = '0;
		skip_r = '0;
		req_end_r = '0;
		hdr_start_r = '0;
		found_off_r = '0;
		found_len_r = '0;
		fault_r = ST_OK;
		done_r = 1'b0;
	endfunction

	function automatic void close_header(int unsigned p);
		int unsigned len;
		int unsigned fin;
		len = acc_r;
		fin = p + 1 + len;
		if (fin > CERT_CAP) begin
			fault_r = ST_TOO_LONG;
			return;
		end
		if (fin > req_end_r)
			req_end_r = fin[16:0];
		if (step_r <= STEP_TBS) begin
			step_r = step_t'(step_r + 3'd1);
			ph_r = PH_TAG;
		end else if (step_r <= STEP_VALIDITY) begin
			step_r = step_t'(step_r + 3'd1);
			if (len == 0) begin
				ph_r = PH_TAG;
			end else begin
				skip_r = len[16:0];
				ph_r = PH_SKIP;
			end
		end else begin
			found_off_r = hdr_start_r[15:0];
			found_len_r = 17'(fin - hdr_start_r);
			done_r = 1'b1;
			step_r = STEP_DONE;
		end
	endfunction

	function automatic void take_byte(logic [7:0] b, int unsigned p);
		logic [4:0]  want;
		logic [24:0] wide;
		case (ph_r)
			PH_TAG: begin
				want = (step_r == STEP_INTEGER) ? TAG_INTEGER : TAG_SEQUENCE;
				hdr_start_r = p[16:0];
				if (b[4:0] == TAG_LONG)
					fault_r = ST_LONG_TAG;
				else if (b[4:0] != want)
					fault_r = ST_BAD_TYPE;
				else
					ph_r = PH_LEN;
			end
			PH_LEN: begin
				if (b <= SHORT_MAX) begin
					acc_r = {9'd0, b};
					close_header(p);
				end else if (b == LEN_INDEFINITE) begin
					fault_r = ST_BAD_LENGTH;
				end else if (b[6:0] > MAX_LENGTH_OCTETS_DEF) begin
					fault_r = ST_BAD_LENGTH;
				end else begin
					octs_r = b[3:0];
					acc_r = '0;
					ph_r = PH_LONG;
				end
			end
			PH_LONG: begin
				// The accumulator saturates one above capacity, so the shift stays in 25 bits.
				wide = {acc_r, b};
				if (wide > CERT_CAP)
					acc_r = 17'(CERT_CAP + 1);
				else
					acc_r = wide[16:0];
				if (octs_r != 0)
					octs_r = octs_r - 4'd1;
				if (octs_r == 0)
					close_header(p);
			end
			default: begin
				if (skip_r != 0)
					skip_r = skip_r - 17'd1;
				if (skip_r == 0)
					ph_r = PH_TAG;
			end
		endcase
	endfunction

	// Advance the predicted walk by one accepted byte; a last byte yields one result.
	function automatic void walk_byte(logic [7:0] b, logic is_last);
		status_t st;
		if (fault_r == ST_OK) begin
			if (pos_r >= CERT_CAP) begin
				fault_r = ST_TOO_LONG;
			end else begin
				if (!done_r)
					take_byte(b, pos_r);
				pos_r = pos_r + 17'd1;
			end
		end
		if (is_last) begin
			st = fault_r;
			if (st == ST_OK && (!done_r || req_end_r > pos_r))
				st = ST_TRUNCATED;
			subject_q.push_back('{st, (st == ST_OK) ? found_off_r : 16'd0,
				(st == ST_OK) ? found_len_r : 17'd0});
			clear_walk();
		end
		taken_cnt++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= 8'h00;
			in_last <= 1'b0;
		end else begin
			if (in_valid && cert_if.ready)
				walk_byte(in_data, in_last);
			if (!in_valid || cert_if.ready) begin
				if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_r = feed_q.pop_front();
					in_valid <= 1'b1;
					in_data <= next_r.data;
					in_last <= next_r.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (subject_q.size() == 0) begin
					$error("result item with nothing pending, status %0d", res_if.status);
					fail_cnt++;
				end else begin
					head_r = subject_q.pop_front();
					if (res_if.status !== head_r.status) begin
						$error("status: expected %0d, got %0d", head_r.status, res_if.status);
						fail_cnt++;
					end
					if (res_if.subject_offset !== head_r.subject_offset) begin
						$error("subject_offset: expected %0d, got %0d",
							head_r.subject_offset, res_if.subject_offset);
						fail_cnt++;
					end
					if (res_if.subject_length !== head_r.subject_length) begin
						$error("subject_length: expected %0d, got %0d",
							head_r.subject_length, res_if.subject_length);
						fail_cnt++;
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One long hold-off on the result side, so the block fills up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			hold_left <= HOLD_CYCS;
			hold_taken <= 1'b1;
		end
	end

	function automatic octets_t rand_bytes(int n);
		octets_t r;
		repeat (n) r.push_back(8'($urandom));
		return r;
	endfunction

	function automatic void append(ref octets_t dst, input octets_t src);
		foreach (src[i]) dst.push_back(src[i]);
	endfunction

	// Tag byte with random class bits, then a short or long form length that may
	// carry leading zero octets.
	function automatic void push_hdr(ref octets_t q, input logic [4:0] code, input int len);
		int need;
		int octs;
		q.push_back({3'($urandom_range(7)), code});
		need = (len < 256) ? 1 : (len < 65536) ? 2 : 3;
		if (len < 128 && $urandom_range(3) != 0) begin
			q.push_back(8'(len));
		end else begin
			octs = ($urandom_range(3) == 0) ? $urandom_range(8, need) : need;
			q.push_back(8'h80 | 8'(octs));
			for (int i = octs - 1; i >= 0; i--)
				q.push_back((i < 4) ? 8'(len >> (8 * i)) : 8'h00);
		end
	endfunction

	function automatic void build_cert(ref octets_t c);
		octets_t body, part, tbs_h, out_h, extra;
		int      tag_at[$];
		int      lie, lie_len, n, pick, cut, base;
		c.delete();
		// Now and then one header declares a length that does not match its content.
		lie = ($urandom_range(9) == 0) ? $urandom_range(6) : -1;
		lie_len = ($urandom_range(1) != 0) ? $urandom_range(70000) : $urandom_range(40);
		for (int k = 0; k < 5; k++) begin
			part = rand_bytes($urandom_range(4));
			tag_at.push_back(body.size());
			push_hdr(body, (k == 0) ? TAG_INTEGER : TAG_SEQUENCE,
				(lie == k + 2) ? lie_len : part.size());
			append(body, part);
		end
		append(body, rand_bytes($urandom_range(3)));
		push_hdr(tbs_h, TAG_SEQUENCE, (lie == 1) ? lie_len : body.size());
		extra = rand_bytes($urandom_range(3));
		push_hdr(out_h, TAG_SEQUENCE,
			(lie == 0) ? lie_len : tbs_h.size() + body.size() + extra.size());
		append(c, out_h);
		append(c, tbs_h);
		append(c, body);
		append(c, extra);
		base = out_h.size() + tbs_h.size();
		foreach (tag_at[i]) tag_at[i] += base;
		tag_at.push_front(out_h.size());
		tag_at.push_front(0);

		pick = $urandom_range(19);
		n = tag_at[$urandom_range(tag_at.size() - 1)];
		if (pick == 11 || pick == 12) begin
			cut = $urandom_range(c.size() - 1);
			c[cut] = c[cut] ^ 8'(1 << $urandom_range(7));
		end else if (pick == 13 || pick == 14) begin
			cut = $urandom_range(c.size(), 1);
			while (c.size() > cut) void'(c.pop_back());
		end else if (pick == 15) begin
			c[n] = (c[n] & 8'he0) | (($urandom_range(1) != 0) ? {3'd0, TAG_LONG} : 8'($urandom_range(31)));
		end else if (pick == 16) begin
			c[n + 1] = ($urandom_range(1) != 0) ? LEN_INDEFINITE : 8'h80 | 8'($urandom_range(127, 9));
		end else if (pick == 17) begin
			c = rand_bytes($urandom_range(6, 1));
		end else if (pick >= 18) begin
			append(c, rand_bytes($urandom_range(4, 1)));
		end
	endfunction

	function automatic void queue_cert(octets_t c);
		foreach (c[i]) feed_q.push_back('{c[i], (i == c.size() - 1)});
		queued_cnt += c.size();
		phase_items += c.size();
		phase_certs++;
	endfunction

	task automatic wait_drained();
		while (taken_cnt != queued_cnt || subject_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		octets_t   c;
		static int send_tab[5] = '{0, 57, 0, 23, 0};
		static int recv_tab[5] = '{0, 0, 57, 23, 0};
		clear_walk();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest well-formed certificate, every element inside the TBS sequence empty.
		c = '{8'h30, 8'h0c, 8'h30, 8'h0a, 8'h02, 8'h00, 8'h30, 8'h00,
			8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00};
		queue_cert(c);
		c = '{8'h1f};
		queue_cert(c);
		c = '{8'h02};
		queue_cert(c);
		c = '{8'h30, 8'h80};
		queue_cert(c);
		c = '{8'h30, 8'h89};
		queue_cert(c);
		c = '{8'h30, 8'h84, 8'h00, 8'h01, 8'h00, 8'h00};
		queue_cert(c);
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			send_idle_pct = send_tab[ph];
			recv_stall_pct = recv_tab[ph];
			phase_items = 0;
			phase_certs = 0;
			while (phase_items < 190 || phase_certs < 8) begin
				// Under result back-pressure, short noise streams bring many last bytes.
				if (ph == 4 && $urandom_range(1) != 0)
					c = rand_bytes($urandom_range(3, 1));
				else
					build_cert(c);
				queue_cert(c);
			end
			if (ph == 4)
				hold_req = 1'b1;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
